/* hw/rtl/ste_pkg.sv */
// Package for the symbol table engine: sizes, label/entry types,
// request and status codes. No dependencies.
`default_nettype none

package ste_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int LABEL_BYTES = 20;
	localparam int LABEL_CHARS = 19;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int HIGH_W = 64;
	localparam int MID_W  = 64;
	localparam int LOW_W  = 24;
	localparam int ADDR_W = 31;
	localparam int LABEL_W = HIGH_W + MID_W + LOW_W;

	// label as one vector: first character in the top byte of hi
	typedef struct packed {
		logic [HIGH_W-1:0] hi;
		logic [MID_W-1:0]  mid;
		logic [LOW_W-1:0]  lo;
	} label_t;

	typedef struct packed {
		label_t            label;
		logic [ADDR_W-1:0] address;
	} entry_t;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_MODIFY = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_SEARCH = 2'd3;

	localparam logic [2:0] STS_INSERTED  = 3'd0;
	localparam logic [2:0] STS_DUPLICATE = 3'd1;
	localparam logic [2:0] STS_UPDATED   = 3'd2;
	localparam logic [2:0] STS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STS_DELETED   = 3'd4;
	localparam logic [2:0] STS_FOUND     = 3'd5;
	localparam logic [2:0] STS_FULL      = 3'd6;

endpackage

`default_nettype wire

/* hw/rtl/ste_label_norm.sv */
// Label normalization: clears every character from the first zero byte on
// and beyond the kept length. Uses ste_pkg.
`default_nettype none

module ste_label_norm (
	input  wire ste_pkg::label_t raw,
	output ste_pkg::label_t      norm
);

	logic [ste_pkg::LABEL_W-1:0] raw_v;
	logic [ste_pkg::LABEL_W-1:0] norm_v;

	assign raw_v = raw;

	// running keep flag: drops at the terminator and stays low
	always_comb begin
		logic       keep;
		logic [7:0] ch;
		keep   = 1'b1;
		norm_v = '0;
		for (int n = 0; n < ste_pkg::LABEL_CHARS; n++) begin
			ch = raw_v[ste_pkg::LABEL_W-1-8*n -: 8];
			if (ch == 8'd0 || n >= ste_pkg::LABEL_BYTES - 1) begin
				keep = 1'b0;
			end
			norm_v[ste_pkg::LABEL_W-1-8*n -: 8] = keep ? ch : 8'd0;
		end
	end

	assign norm = norm_v;

endmodule

`default_nettype wire

/* hw/rtl/ste_table_mem.sv */
// Entry store of the symbol table: one write port, one read port with
// registered read data. Uses ste_pkg.
`default_nettype none

module ste_table_mem (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire  [ste_pkg::IDX_W-1:0]  wr_addr,
	input  wire  ste_pkg::entry_t      wr_data,
	input  wire  [ste_pkg::IDX_W-1:0]  rd_addr,
	output ste_pkg::entry_t            rd_data
);

	ste_pkg::entry_t mem_q [ste_pkg::TABLE_DEPTH];
	ste_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/symbol_table_engine_unit.sv */
// Symbol table engine top level: stream ports, scan/shift sequencer and the
// shared label comparator. Uses ste_pkg, ste_label_norm, ste_table_mem.
//
// Usage:
//  - Requests arrive on the s_ channel: tuser carries the action (insert,
//    modify, delete, search), tdata the label words and the address.
//  - Each request gives exactly one response transfer on the m_ channel:
//    a status code and the entry count after the request.
//  - The label is cut at its first zero byte, then the table is scanned in
//    order through one read port; one comparator checks one stored label
//    per cycle, the first match wins.
//  - A delete that hits then walks the tail of the table one entry per cycle,
//    moving each entry down by one.
//  - Throughput: one request at a time; s_tready is high only while the
//    sequencer is idle, from the cycle after the response is loaded. A request
//    may be taken while the previous response still waits in the output
//    register.
//  - Backpressure: if m_tready is low, the finished response waits inside
//    the sequencer until the output register frees; nothing is dropped.
//  - Reset (arst_n low) empties the table (count 0) and clears the output
//    register; entry storage itself is not cleared, entries at or above
//    the count are never read.
`default_nettype none

module symbol_table_engine_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [63:0] label_high, [127:64] label_mid, [151:128] label_low,
	// [182:152] address, [183] zero
	input  wire  [183:0] s_tdata,
	// [1:0] action
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// [2:0] status, [9:3] entry_count, [15:10] zero
	output logic [15:0]  m_tdata
);

	localparam int CNT_W = ste_pkg::CNT_W;
	localparam int IDX_W = ste_pkg::IDX_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]                  state_q;
	logic [1:0]                  action_q;
	ste_pkg::label_t             key_q;
	logic [ste_pkg::ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            ptr_q;
	logic                        pend_s1;
	logic [CNT_W-1:0]            idx_s1;
	logic [2:0]                  result_q;
	logic                        m_tvalid_q;
	logic [2:0]                  m_status_q;
	logic [CNT_W-1:0]            m_count_q;

	ste_pkg::label_t             raw_label;
	ste_pkg::label_t             norm_label;
	ste_pkg::entry_t             rd_data;
	ste_pkg::entry_t             wr_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [CNT_W-1:0]            idx_dec;
	logic                        s_xfer;
	logic                        out_free;
	logic                        issue;
	logic                        hit;
	logic                        drained;
	logic                        leave;
	logic                        shift_start;

	// hi, mid, lo from the top of the packed label down
	assign raw_label = {s_tdata[63:0], s_tdata[127:64], s_tdata[151:128]};

	ste_label_norm u_norm (
		.raw  (raw_label),
		.norm (norm_label)
	);

	ste_table_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// read pipeline: address issued at ptr_q, data compared in the next cycle
	assign issue   = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (ptr_q < count_q);
	assign hit     = pend_s1 && (rd_data.label == key_q);
	assign drained = !pend_s1 && (ptr_q >= count_q);
	assign leave   = ((state_q == S_SCAN) && (hit || drained)) ||
	                 ((state_q == S_SHIFT) && drained);
	assign idx_dec = idx_s1 - CNT_W'(1);
	assign shift_start = (state_q == S_SCAN) && hit && (action_q == ste_pkg::ACT_DELETE);

	// table writes: append on insert, address update on modify, move-down on delete
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = '0;
		unique case (state_q)
			S_SCAN: begin
				if (hit && action_q == ste_pkg::ACT_MODIFY) begin
					wr_en           = 1'b1;
					wr_addr         = idx_s1[IDX_W-1:0];
					wr_data.label   = key_q;
					wr_data.address = addr_q;
				end else if (!hit && drained && action_q == ste_pkg::ACT_INSERT &&
				             count_q < CNT_W'(ste_pkg::TABLE_DEPTH)) begin
					wr_en           = 1'b1;
					wr_addr         = count_q[IDX_W-1:0];
					wr_data.label   = key_q;
					wr_data.address = addr_q;
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_dec[IDX_W-1:0];
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			action_q <= s_tuser;
			key_q    <= norm_label;
			addr_q   <= s_tdata[182:152];
		end
		idx_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			pend_s1    <= 1'b0;
			result_q   <= ste_pkg::STS_NOT_FOUND;
			m_tvalid_q <= 1'b0;
			m_status_q <= ste_pkg::STS_NOT_FOUND;
			m_count_q  <= '0;
		end else begin
			pend_s1 <= issue && !leave;
			if (issue && !shift_start) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			// S_DONE reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						ptr_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						unique case (action_q)
							ste_pkg::ACT_INSERT: begin
								result_q <= ste_pkg::STS_DUPLICATE;
								state_q  <= S_DONE;
							end
							ste_pkg::ACT_MODIFY: begin
								result_q <= ste_pkg::STS_UPDATED;
								state_q  <= S_DONE;
							end
							ste_pkg::ACT_DELETE: begin
								// tail walk starts at the entry after the match
								ptr_q   <= idx_s1 + CNT_W'(1);
								state_q <= S_SHIFT;
							end
							ste_pkg::ACT_SEARCH: begin
								result_q <= ste_pkg::STS_FOUND;
								state_q  <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else if (drained) begin
						state_q <= S_DONE;
						if (action_q == ste_pkg::ACT_INSERT) begin
							if (count_q >= CNT_W'(ste_pkg::TABLE_DEPTH)) begin
								result_q <= ste_pkg::STS_FULL;
							end else begin
								count_q  <= count_q + CNT_W'(1);
								result_q <= ste_pkg::STS_INSERTED;
							end
						end else begin
							result_q <= ste_pkg::STS_NOT_FOUND;
						end
					end
				end
				S_SHIFT: begin
					if (drained) begin
						count_q  <= count_q - CNT_W'(1);
						result_q <= ste_pkg::STS_DELETED;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= result_q;
						m_count_q  <= count_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - 3 - CNT_W){1'b0}}, m_count_q, m_status_q};

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for symbol_table_engine_unit: directed table plus random
// insert/modify/delete/search traffic checked against a shadow table.
// Depends on ste_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb;

	localparam int CNT_W = ste_pkg::CNT_W;
	localparam int ADDR_W = ste_pkg::ADDR_W;
	localparam int LABEL_W = ste_pkg::LABEL_W;
	localparam int LABEL_CHARS = ste_pkg::LABEL_CHARS;
	localparam int LABEL_BYTES = ste_pkg::LABEL_BYTES;
	localparam int TABLE_DEPTH = ste_pkg::TABLE_DEPTH;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int POOL_SIZE = 80;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 220;
	localparam int N_DIRECTED = 19;

	// traffic mixes for the random phases
	localparam int MIX_FILL = 0;
	localparam int MIX_EVEN = 1;
	localparam int MIX_DRAIN = 2;

	typedef struct packed {
		logic [2:0]       status;
		logic [CNT_W-1:0] count;
	} answer_t;

	typedef struct packed {
		logic [1:0]        action;
		ste_pkg::label_t   label;
		logic [ADDR_W-1:0] address;
		logic              known;   // expected answer typed into the row
		logic [2:0]        status;
		logic [CNT_W-1:0]  count;
	} request_t;

	// directed labels; bytes after the first zero byte must be ignored
	localparam ste_pkg::label_t L_EMPTY = '0;
	localparam ste_pkg::label_t L_ONES =
		{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF};
	localparam ste_pkg::label_t L_A_JUNK =
		{64'h4100_DEAD_BEEF_0001, 64'hFFFF_FFFF_FFFF_FFFF, 24'h12_3456};
	localparam ste_pkg::label_t L_A_JUNK2 = {64'h4100_0000_0000_0080, 64'h0, 24'hFF_0000};
	localparam ste_pkg::label_t L_A = {64'h4100_0000_0000_0000, 64'h0, 24'h0};
	localparam ste_pkg::label_t L_MID =
		{64'h6162_6364_6566_6768, 64'h6900_FF7F_0102_0304, 24'hAB_CDEF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [183:0] s_tdata = '0;
	logic [1:0] s_tuser = ste_pkg::ACT_SEARCH;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 9;
	int stall_pct = 9;

	// shadow of the engine's table
	ste_pkg::label_t stored_label [TABLE_DEPTH];
	logic [ADDR_W-1:0] stored_addr [TABLE_DEPTH];
	int stored_count = 0;

	answer_t answer_q [$];

	ste_pkg::label_t pool_label [POOL_SIZE];
	int pool_len [POOL_SIZE];

	request_t directed_rows [N_DIRECTED] = '{
		'{ste_pkg::ACT_SEARCH, L_EMPTY,   31'd0,         1'b1, ste_pkg::STS_NOT_FOUND, 7'd0},
		'{ste_pkg::ACT_MODIFY, L_EMPTY,   31'd5,         1'b1, ste_pkg::STS_NOT_FOUND, 7'd0},
		'{ste_pkg::ACT_DELETE, L_ONES,    31'd0,         1'b1, ste_pkg::STS_NOT_FOUND, 7'd0},
		'{ste_pkg::ACT_INSERT, L_EMPTY,   31'd0,         1'b1, ste_pkg::STS_INSERTED,  7'd1},
		'{ste_pkg::ACT_INSERT, L_ONES,    31'h7FFF_FFFF, 1'b1, ste_pkg::STS_INSERTED,  7'd2},
		'{ste_pkg::ACT_INSERT, L_EMPTY,   31'd123,       1'b1, ste_pkg::STS_DUPLICATE, 7'd2},
		'{ste_pkg::ACT_INSERT, L_A_JUNK,  31'd1,         1'b1, ste_pkg::STS_INSERTED,  7'd3},
		'{ste_pkg::ACT_SEARCH, L_A_JUNK2, 31'd0,         1'b1, ste_pkg::STS_FOUND,     7'd3},
		'{ste_pkg::ACT_INSERT, L_A,       31'd2,         1'b1, ste_pkg::STS_DUPLICATE, 7'd3},
		'{ste_pkg::ACT_MODIFY, L_A_JUNK2, 31'h7FFF_FFFF, 1'b1, ste_pkg::STS_UPDATED,   7'd3},
		'{ste_pkg::ACT_INSERT, L_MID,     31'h2AAA_5555, 1'b1, ste_pkg::STS_INSERTED,  7'd4},
		'{ste_pkg::ACT_SEARCH, L_MID,     31'h5555_2AAA, 1'b1, ste_pkg::STS_FOUND,     7'd4},
		'{ste_pkg::ACT_DELETE, L_EMPTY,   31'd0,         1'b1, ste_pkg::STS_DELETED,   7'd3},
		'{ste_pkg::ACT_SEARCH, L_EMPTY,   31'd0,         1'b1, ste_pkg::STS_NOT_FOUND, 7'd3},
		'{ste_pkg::ACT_SEARCH, L_ONES,    31'd0,         1'b1, ste_pkg::STS_FOUND,     7'd3},
		'{ste_pkg::ACT_DELETE, L_MID,     31'd0,         1'b1, ste_pkg::STS_DELETED,   7'd2},
		'{ste_pkg::ACT_DELETE, L_A,       31'd0,         1'b1, ste_pkg::STS_DELETED,   7'd1},
		'{ste_pkg::ACT_DELETE, L_ONES,    31'd0,         1'b1, ste_pkg::STS_DELETED,   7'd0},
		'{ste_pkg::ACT_DELETE, L_ONES,    31'd0,         1'b1, ste_pkg::STS_NOT_FOUND, 7'd0}
	};

	symbol_table_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cut the label at its first zero byte and keep LABEL_BYTES-1 chars
	function automatic ste_pkg::label_t clean_label(input ste_pkg::label_t raw);
		ste_pkg::label_t kept;
		logic ended;
		kept = '0;
		ended = 1'b0;
		for (int n = 0; n < LABEL_CHARS; n++) begin
			if (raw[LABEL_W-1-8*n -: 8] == 8'd0 || n >= LABEL_BYTES - 1)
				ended = 1'b1;
			if (!ended)
				kept[LABEL_W-1-8*n -: 8] = raw[LABEL_W-1-8*n -: 8];
		end
		return kept;
	endfunction

	// apply one request to the shadow table and work out its answer
	task automatic predict_answer(input request_t r, output answer_t a);
		ste_pkg::label_t key;
		int hit;
		key = clean_label(r.label);
		hit = -1;
		for (int i = 0; i < stored_count; i++)
			if (hit < 0 && stored_label[i] == key)
				hit = i;
		a.status = ste_pkg::STS_NOT_FOUND;
		case (r.action)
			ste_pkg::ACT_INSERT: begin
				if (hit >= 0) begin
					a.status = ste_pkg::STS_DUPLICATE;
				end else if (stored_count >= TABLE_DEPTH) begin
					a.status = ste_pkg::STS_FULL;
				end else begin
					stored_label[stored_count] = key;
					stored_addr[stored_count] = r.address;
					stored_count++;
					a.status = ste_pkg::STS_INSERTED;
				end
			end
			ste_pkg::ACT_MODIFY: begin
				if (hit >= 0) begin
					stored_addr[hit] = r.address;
					a.status = ste_pkg::STS_UPDATED;
				end
			end
			ste_pkg::ACT_DELETE: begin
				if (hit >= 0) begin
					// close the gap, order is kept
					for (int j = hit; j + 1 < stored_count; j++) begin
						stored_label[j] = stored_label[j + 1];
						stored_addr[j] = stored_addr[j + 1];
					end
					stored_count--;
					a.status = ste_pkg::STS_DELETED;
				end
			end
			default: begin
				if (hit >= 0)
					a.status = ste_pkg::STS_FOUND;
			end
		endcase
		a.count = CNT_W'(stored_count);
	endtask

	// drive one request and hold it until the transfer; s_tvalid stays high
	// into the next request unless an idle cycle is rolled
	task automatic send_request(input request_t r);
		answer_t a;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.action;
		s_tdata <= {1'b0, r.address, r.label.lo, r.label.mid, r.label.hi};
		do @(posedge clk); while (!s_tready);
		predict_answer(r, a);
		if (r.known) begin
			a.status = r.status;
			a.count = r.count;
		end
		answer_q.push_back(a);
	endtask

	task automatic make_random_request(input int mix, output request_t r);
		int roll, ins, mdf, del, pick;
		r = '0;
		case (mix)
			MIX_FILL: begin
				ins = 70; mdf = 10; del = 5;
			end
			MIX_EVEN: begin
				ins = 25; mdf = 25; del = 25;
			end
			default: begin
				ins = 20; mdf = 10; del = 55;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < ins)
			r.action = ste_pkg::ACT_INSERT;
		else if (roll < ins + mdf)
			r.action = ste_pkg::ACT_MODIFY;
		else if (roll < ins + mdf + del)
			r.action = ste_pkg::ACT_DELETE;
		else
			r.action = ste_pkg::ACT_SEARCH;
		if ($urandom_range(99) < 8) begin
			// noise: raw random bytes, mostly labels never seen before
			for (int n = 0; n < LABEL_CHARS; n++)
				r.label[LABEL_W-1-8*n -: 8] = 8'($urandom_range(255));
		end else begin
			pick = $urandom_range(POOL_SIZE - 1);
			r.label = pool_label[pick];
			if ($urandom_range(1) == 1)
				for (int n = pool_len[pick] + 1; n < LABEL_CHARS; n++)
					r.label[LABEL_W-1-8*n -: 8] = 8'($urandom_range(255));
		end
		r.address = ADDR_W'($urandom);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				error_count++;
				$error("response with none pending: status %0d entry_count %0d",
					m_tdata[2:0], m_tdata[9:3]);
			end else begin
				want = answer_q.pop_front();
				if (m_tdata[2:0] !== want.status) begin
					error_count++;
					$error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
				end
				if (m_tdata[9:3] !== want.count) begin
					error_count++;
					$error("entry_count: expected %0d, actual %0d", want.count,
						m_tdata[9:3]);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		request_t r;
		// label pool: every length 0..19 at least once, nonzero characters
		for (int p = 0; p < POOL_SIZE; p++) begin
			pool_len[p] = (p <= LABEL_CHARS) ? p : $urandom_range(LABEL_CHARS);
			pool_label[p] = '0;
			for (int n = 0; n < pool_len[p]; n++)
				pool_label[p][LABEL_W-1-8*n -: 8] = 8'($urandom_range(1, 255));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i]);

		// fill to full, churn near full, drain, repeated; one phase without idling or stalls
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = (ph == 4) ? 0 : 9;
			stall_pct = idle_pct;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				make_random_request(ph % 3, r);
				send_request(r);
			end
		end
		s_tvalid <= 1'b0;

		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ste_pkg.sv
hw/rtl/ste_label_norm.sv
hw/rtl/ste_table_mem.sv
hw/rtl/symbol_table_engine_unit.sv
tb/tb.sv
